// ===== rtl/dmq_pkg.sv =====
// shared constants and control types for the dedup move-to-back queue
package dmq_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_POP = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic compare;
    logic update;
    logic load_out;
  } dmq_ctl_t;

endpackage

// ===== rtl/dmq_req_if.sv =====
// request and response channel interfaces
interface dmq_req_if
  import dmq_pkg::*;
();

  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface dmq_rsp_if
  import dmq_pkg::*;
();

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] front_value;
  logic                    nonempty;
  logic [CNT_W-1:0]        entry_count;
  logic                    underflow_error;

  modport source (output valid, output front_value, output nonempty, output entry_count,
                  output underflow_error, input ready);
  modport sink   (input valid, input front_value, input nonempty, input entry_count,
                  input underflow_error, output ready);
endinterface

// ===== rtl/dedup_move_to_back_queue.sv =====
// top level: deduplicating move-to-back queue
//
// The req channel carries one word per command: cmd (add or pop) and value.
// Each accepted word yields exactly one word on the rsp channel with the
// front entry, a nonempty flag, the entry count and an underflow flag.
// An add of a held value moves it to the back; a new value is appended,
// or overwrites the back entry when the list holds capacity entries.
// A pop on an empty list only raises underflow_error.
// The capacity register is written through cfg_write_en / cfg_write_data;
// the user must write it only while the block is idle, which the block
// itself does not enforce; the register resets to 16.
// The controller steps through accept, parallel compare over all entries,
// shift update and response, and takes no new command before the response step is done.
// The response sits in an output register; while the receiver stalls it
// holds, and a finished command waits in its response step until the
// register is free, so no new request is taken meanwhile.
// Reset (rst, synchronous) empties the list and clears the response valid flag.
module dedup_move_to_back_queue
  import dmq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  dmq_req_if.sink          req,
  dmq_rsp_if.source        rsp,
  input  logic             cfg_write_en,
  input  logic [CAP_W-1:0] cfg_write_data
);

  dmq_ctl_t ctl;

  // sequencing
  dmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .ctl       (ctl)
  );

  // storage and arithmetic
  dmq_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .req_cmd         (req.cmd),
    .req_value       (req.value),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .front_value     (rsp.front_value),
    .nonempty        (rsp.nonempty),
    .entry_count     (rsp.entry_count),
    .underflow_error (rsp.underflow_error)
  );

endmodule

// ===== rtl/dmq_ctrl.sv =====
// controller state machine: sequences compare, update and response load
module dmq_ctrl
  import dmq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output dmq_ctl_t ctl
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_UPDATE,
    ST_RESPOND
  } state_t;

  state_t state;
  logic   out_valid;
  logic   out_free;

  assign out_free  = !out_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = out_valid;

  // datapath commands decoded from state
  assign ctl.load_in  = (state == ST_IDLE) && req_valid;
  assign ctl.compare  = (state == ST_COMPARE);
  assign ctl.update   = (state == ST_UPDATE);
  assign ctl.load_out = (state == ST_RESPOND) && out_free;

  // state and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid) state <= ST_COMPARE;
        end
        ST_COMPARE: state <= ST_UPDATE;
        ST_UPDATE:  state <= ST_RESPOND;
        ST_RESPOND: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/dmq_datapath.sv =====
// entry store, parallel compare, shift update and response register
module dmq_datapath
  import dmq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  dmq_ctl_t                ctl,
  input  logic                    req_cmd,
  input  logic signed [VAL_W-1:0] req_value,
  input  logic                    cfg_write_en,
  input  logic [CAP_W-1:0]        cfg_write_data,
  output logic signed [VAL_W-1:0] front_value,
  output logic                    nonempty,
  output logic [CNT_W-1:0]        entry_count,
  output logic                    underflow_error
);

  logic [VAL_W-1:0]       entries [MAX_ENTRIES];
  logic [CNT_W-1:0]       held_count;
  logic [CAP_W-1:0]       capacity;
  logic                   cmd_q;
  logic [VAL_W-1:0]       value_q;
  logic [MAX_ENTRIES-1:0] match_q;
  logic                   underflow_q;

  logic [CNT_W-1:0]       eff_cap;
  logic [MAX_ENTRIES-1:0] match_now;
  logic                   found;
  logic                   has_room;
  logic [CNT_W-1:0]       wpos;
  logic [MAX_ENTRIES-1:0] shift_en;
  logic [MAX_ENTRIES-1:0] write_en;
  logic [CNT_W-1:0]       count_next;
  logic                   pop_empty;

  // capacity clamped to 1..MAX_ENTRIES
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if (CNT_W'(capacity) > CNT_W'(MAX_ENTRIES)) begin
      eff_cap = CNT_W'(MAX_ENTRIES);
    end else begin
      eff_cap = CNT_W'(capacity);
    end
  end

  // compare the word against every held entry
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match_now[i] = (entries[i] == value_q) && (CNT_W'(i) < held_count);
    end
  end

  assign found     = (cmd_q == CMD_ADD) && (match_q != '0);
  assign has_room  = held_count < eff_cap;
  assign pop_empty = (cmd_q == CMD_POP) && (held_count == '0);

  // back position written by an add
  always_comb begin
    if (!found && has_room) begin
      wpos = held_count;
    end else begin
      wpos = held_count - CNT_W'(1);
    end
  end

  // per-entry shift and write enables
  always_comb begin
    logic after;
    after = 1'b0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      after = after | match_q[i];
      if (cmd_q == CMD_POP) begin
        shift_en[i] = (CNT_W'(i + 1) < held_count);
        write_en[i] = 1'b0;
      end else begin
        shift_en[i] = found && after && (CNT_W'(i + 1) < held_count);
        write_en[i] = (CNT_W'(i) == wpos);
      end
    end
  end

  // count after the command
  always_comb begin
    count_next = held_count;
    if (cmd_q == CMD_POP) begin
      if (held_count != '0) count_next = held_count - CNT_W'(1);
    end else if (!found && has_room) begin
      count_next = held_count + CNT_W'(1);
    end
  end

  // entry store, no reset
  always_ff @(posedge clk) begin
    if (ctl.update) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (write_en[i]) begin
          entries[i] <= value_q;
        end else if (shift_en[i] && i + 1 < MAX_ENTRIES) begin
          entries[i] <= entries[(i + 1) % MAX_ENTRIES];
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      capacity   <= CAP_W'(MAX_ENTRIES);
    end else begin
      if (cfg_write_en) capacity <= cfg_write_data;
      if (ctl.update) held_count <= count_next;
    end
  end

  // input word, compare result and response registers
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_q   <= req_cmd;
      value_q <= req_value;
    end
    if (ctl.compare) match_q <= match_now;
    if (ctl.update) underflow_q <= pop_empty;
    if (ctl.load_out) begin
      front_value     <= (held_count != '0) ? entries[0] : '0;
      nonempty        <= (held_count != '0);
      entry_count     <= held_count;
      underflow_error <= underflow_q;
    end
  end

endmodule
